>>> src/pie_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pie_pkg: shared definitions for the positional insert/erase list
// Field widths, operation and status codes, and the control group that the
// list controller broadcasts to every storage cell.
// ----------------------------------------------------------------------------
package pie_pkg;

    localparam int DATA_W       = 32;
    localparam int POS_W        = 5;
    localparam int OP_W         = 2;
    localparam int ST_W         = 2;
    localparam int CNT_OUT_W    = 5;
    localparam int DEF_CAPACITY = 16;

    // Operation codes carried on the input channel.
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_ERASE  = 2'd1;
    localparam logic [OP_W-1:0] OP_DUMP   = 2'd2;

    // Status codes reported with every result.
    localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD_POS = 2'd2;

    // Commands broadcast to the cell chain.
    localparam logic [1:0] CMD_HOLD   = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_ERASE  = 2'd2;
    localparam logic [1:0] CMD_ROTATE = 2'd3;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [DATA_W-1:0] value;  // new entry for an insert
        logic [DATA_W-1:0] head;   // entry of cell 0, wrapped to the tail on rotate
    } cell_ctrl_t;

endpackage
`default_nettype wire

>>> src/pie_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pie_cell: one storage cell of the list chain
// Holds a single entry and, on each command, keeps it, takes the entry of a
// neighbor, takes the new value or takes the wrapped head entry.
// ----------------------------------------------------------------------------
module pie_cell #(
    parameter int IDX = 0,
    parameter int IW  = 5
) (
    input  wire                        aclk,
    input  wire pie_pkg::cell_ctrl_t   ctrl,
    input  wire  [IW-1:0]              pos,
    input  wire  [IW-1:0]              cnt,
    input  wire  [pie_pkg::DATA_W-1:0] prev_data,
    input  wire  [pie_pkg::DATA_W-1:0] next_data,
    output logic [pie_pkg::DATA_W-1:0] data
);
    import pie_pkg::*;

    localparam logic [IW-1:0] IDX_V  = IW'(IDX);
    localparam logic [IW-1:0] IDX_P1 = IW'(IDX + 1);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        case (ctrl.cmd)
            CMD_INSERT: begin
                if (IDX_V == pos) begin
                    data_next = ctrl.value;
                end else if (IDX_V > pos) begin
                    data_next = prev_data;
                end
            end
            CMD_ERASE: begin
                if (IDX_V >= pos) begin
                    data_next = next_data;
                end
            end
            CMD_ROTATE: begin
                // The cell at the tail of the used region takes the old head.
                if (IDX_P1 == cnt) begin
                    data_next = ctrl.head;
                end else if (IDX_P1 < cnt) begin
                    data_next = next_data;
                end
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule
`default_nettype wire

>>> src/positional_insert_erase_list_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// positional_insert_erase_list_unit: ordered list with positional edits
// Keeps up to LIST_CAPACITY signed entries in a chain of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one command item: s_tuser is the operation (insert,
//   erase, dump), s_tdata carries the position and the value to insert.
//   The m_ channel returns result items: status and element-valid flag in
//   m_tuser, element and entry count in m_tdata, and m_tlast on the final
//   result of each command.
//   Insert and erase shift the whole cell chain at the accepting edge and
//   register their one result at that edge, so they run at one
//   item per cycle while the receiver keeps up.
//   A dump of N entries holds the input until it ends: the accepting edge only
//   enters the dump state, then one entry per cycle leaves while the receiver
//   keeps up, as the chain rotates its used region toward cell 0; it is back in
//   order when the last entry leaves. No input item is taken during a dump.
//   A stalled receiver holds the output register; the chain and the dump
//   counter wait with it. Reset empties the list and drops any pending
//   result; entry storage itself is not cleared.
// ----------------------------------------------------------------------------
module positional_insert_erase_list_unit #(
    parameter int LIST_CAPACITY = pie_pkg::DEF_CAPACITY
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [39:0] s_tdata,   // [4:0] position, [36:5] item_value, rest zero
    input  wire  [1:0]  s_tuser,   // [1:0] operation
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata,   // [31:0] element, [36:32] entry_count, rest zero
    output logic [2:0]  m_tuser,   // [1:0] status, [2] element_valid
    output logic        m_tlast
);
    import pie_pkg::*;

    localparam int CW = $clog2(LIST_CAPACITY + 1);
    localparam int IW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] CAP_V = CW'(LIST_CAPACITY);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DUMP = 1'b1;

    logic              state_reg,      state_next;
    logic [CW-1:0]     count_reg,      count_next;
    logic [CW-1:0]     dump_idx_reg,   dump_idx_next;
    logic              out_valid_reg,  out_valid_next;
    logic [ST_W-1:0]   out_status_reg, out_status_next;
    logic [DATA_W-1:0] out_elem_reg,   out_elem_next;
    logic              out_evalid_reg, out_evalid_next;
    logic              out_last_reg,   out_last_next;
    logic [CNT_OUT_W-1:0] out_count_reg, out_count_next;

    logic [OP_W-1:0]   in_op;
    logic [POS_W-1:0]  in_pos;
    logic [DATA_W-1:0] in_value;
    logic [IW-1:0]     pos_ext;
    logic [IW-1:0]     cnt_ext;
    logic              out_free;
    logic              in_fire;
    logic              dump_last;
    cell_ctrl_t        ctrl;
    logic [DATA_W-1:0] cell_data [LIST_CAPACITY];

    assign in_op    = s_tuser;
    assign in_pos   = s_tdata[POS_W-1:0];
    assign in_value = s_tdata[POS_W+DATA_W-1:POS_W];
    assign pos_ext  = IW'(in_pos);
    assign cnt_ext  = IW'(count_reg);

    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) && out_free;
    assign in_fire   = s_tvalid && s_tready;
    assign dump_last = (CW'(dump_idx_reg + 1'b1) == count_reg);

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        dump_idx_next   = dump_idx_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_elem_next   = out_elem_reg;
        out_evalid_next = out_evalid_reg;
        out_last_next   = out_last_reg;
        out_count_next  = out_count_reg;
        ctrl.cmd        = CMD_HOLD;
        ctrl.value      = in_value;
        ctrl.head       = cell_data[0];

        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_DONE;
                    out_elem_next   = '0;
                    out_evalid_next = 1'b0;
                    out_last_next   = 1'b1;
                    case (in_op)
                        OP_INSERT: begin
                            // Fullness takes precedence over a bad position.
                            if (count_reg == CAP_V) begin
                                out_status_next = ST_FULL;
                            end else if (pos_ext > cnt_ext) begin
                                out_status_next = ST_BAD_POS;
                            end else begin
                                ctrl.cmd   = CMD_INSERT;
                                count_next = CW'(count_reg + 1'b1);
                            end
                        end
                        OP_ERASE: begin
                            if (pos_ext >= cnt_ext) begin
                                out_status_next = ST_BAD_POS;
                            end else begin
                                ctrl.cmd   = CMD_ERASE;
                                count_next = CW'(count_reg - 1'b1);
                            end
                        end
                        OP_DUMP: begin
                            if (count_reg != '0) begin
                                out_valid_next = 1'b0;
                                dump_idx_next  = '0;
                                state_next     = S_DUMP;
                            end
                        end
                        default: begin
                            out_status_next = ST_DONE;
                        end
                    endcase
                    out_count_next = CNT_OUT_W'(count_next);
                end
            end
            S_DUMP: begin
                if (out_free) begin
                    ctrl.cmd        = CMD_ROTATE;
                    out_valid_next  = 1'b1;
                    out_status_next = ST_DONE;
                    out_elem_next   = cell_data[0];
                    out_evalid_next = 1'b1;
                    out_last_next   = dump_last;
                    out_count_next  = CNT_OUT_W'(count_reg);
                    dump_idx_next   = CW'(dump_idx_reg + 1'b1);
                    if (dump_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            dump_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dump_idx_reg  <= dump_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_status_reg <= out_status_next;
        out_elem_reg   <= out_elem_next;
        out_evalid_reg <= out_evalid_next;
        out_last_reg   <= out_last_next;
        out_count_reg  <= out_count_next;
    end

    // Cell chain: each cell sees its lower and upper neighbor.
    for (genvar i = 0; i < LIST_CAPACITY; i++) begin : g_cell
        logic [DATA_W-1:0] prev_d;
        logic [DATA_W-1:0] next_d;
        if (i == 0) begin : g_first
            assign prev_d = '0;
        end else begin : g_mid_lo
            assign prev_d = cell_data[i-1];
        end
        if (i == LIST_CAPACITY - 1) begin : g_last
            assign next_d = '0;
        end else begin : g_mid_hi
            assign next_d = cell_data[i+1];
        end
        pie_cell #(
            .IDX (i),
            .IW  (IW)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .pos       (pos_ext),
            .cnt       (cnt_ext),
            .prev_data (prev_d),
            .next_data (next_d),
            .data      (cell_data[i])
        );
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_evalid_reg, out_status_reg};
    assign m_tdata  = {3'b000, out_count_reg, out_elem_reg};

    // The count never runs past the capacity.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_V)
        else $error("entry count exceeds capacity");

    // While a dump streams out, no new command may enter.
    a_dump_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DUMP) |-> !s_tready)
        else $error("input taken during dump");

    // An insert into a full list is refused and leaves the count alone.
    a_full_refused: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && (in_op == OP_INSERT) && (count_reg == CAP_V)) |=>
        (m_tvalid && (out_status_reg == ST_FULL) && $stable(count_reg)))
        else $error("insert into full list not refused");

    // A dump ends with the last entry flagged and the count unchanged.
    a_dump_end: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_DUMP) && out_free && dump_last) |=>
        (m_tvalid && m_tlast && (state_reg == S_IDLE) && $stable(count_reg)))
        else $error("dump did not end cleanly");

endmodule
`default_nettype wire

>>> tb/positional_insert_erase_list_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_insert_erase_list_unit_tb: self-checking bench for the list unit
// Drives insert, erase, dump and unused-code commands through the s_ stream,
// keeps a shadow copy of the list to work out every expected result, and
// compares every field of each m_ item. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module positional_insert_erase_list_unit_tb;
    import pie_pkg::*;

    localparam int                CAPACITY       = DEF_CAPACITY;
    localparam logic [OP_W-1:0]   OP_UNUSED      = 2'd3;
    localparam int                TIMEOUT_CYCLES = 200000;
    localparam int                RANDOM_ITEMS   = 200;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] value;
        logic                     drain_first;  // hold back until the output side is empty
    } list_cmd_t;

    typedef struct packed {
        logic [ST_W-1:0]          status;
        logic signed [DATA_W-1:0] element;
        logic                     elem_valid;
        logic                     last;
        logic [CNT_OUT_W-1:0]     count;
    } list_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // [4:0] position, [36:5] item_value, rest zero
    logic [1:0]  s_tuser  = '0;   // [1:0] operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // [31:0] element, [36:32] entry_count, rest zero
    logic [2:0]  m_tuser;         // [1:0] status, [2] element_valid
    logic        m_tlast;

    positional_insert_erase_list_unit #(
        .LIST_CAPACITY(CAPACITY)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always #5 aclk = ~aclk;

    list_cmd_t                cmd_q[$];
    list_result_t             expected_results[$];
    logic signed [DATA_W-1:0] shadow_list[CAPACITY];
    int                       shadow_len = 0;
    int                       plan_len   = 0;

    int error_count    = 0;
    int cmds_accepted  = 0;
    int results_seen   = 0;
    int dumps_done     = 0;
    int full_refusals  = 0;
    int bad_positions  = 0;
    int peak_len       = 0;

    // Shadow of the list: applies one accepted command and queues its results.
    task automatic apply_list_cmd(input list_cmd_t c);
        list_result_t r;
        int           i;
        r.status     = ST_DONE;
        r.element    = '0;
        r.elem_valid = 1'b0;
        r.last       = 1'b1;
        case (c.op)
            OP_INSERT: begin
                if (shadow_len >= CAPACITY) begin
                    r.status = ST_FULL;
                    full_refusals++;
                end else if (c.pos > shadow_len) begin
                    r.status = ST_BAD_POS;
                    bad_positions++;
                end else begin
                    for (i = shadow_len; i > c.pos; i--)
                        shadow_list[i] = shadow_list[i-1];
                    shadow_list[c.pos] = c.value;
                    shadow_len++;
                end
            end
            OP_ERASE: begin
                if (c.pos >= shadow_len) begin
                    r.status = ST_BAD_POS;
                    bad_positions++;
                end else begin
                    for (i = c.pos; i + 1 < shadow_len; i++)
                        shadow_list[i] = shadow_list[i+1];
                    shadow_len--;
                end
            end
            OP_DUMP: begin
                dumps_done++;
                if (shadow_len > 0) begin
                    for (i = 0; i < shadow_len - 1; i++) begin
                        r.element    = shadow_list[i];
                        r.elem_valid = 1'b1;
                        r.last       = 1'b0;
                        r.count      = shadow_len[CNT_OUT_W-1:0];
                        expected_results.push_back(r);
                    end
                    r.element    = shadow_list[shadow_len-1];
                    r.elem_valid = 1'b1;
                    r.last       = 1'b1;
                end
            end
            default: ;
        endcase
        r.count = shadow_len[CNT_OUT_W-1:0];
        expected_results.push_back(r);
        if (shadow_len > peak_len)
            peak_len = shadow_len;
    endtask

    // Queues a command and tracks the planned list length so that random
    // positions can be aimed at the valid range.
    task automatic add_cmd(input logic [OP_W-1:0] op, input int pos,
                           input logic [DATA_W-1:0] value, input logic drain);
        list_cmd_t c;
        c.op          = op;
        c.pos         = pos[POS_W-1:0];
        c.value       = value;
        c.drain_first = drain;
        cmd_q.push_back(c);
        if (op == OP_INSERT && plan_len < CAPACITY && pos <= plan_len)
            plan_len++;
        else if (op == OP_ERASE && pos < plan_len)
            plan_len--;
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    // Driver: presents queued commands with a random gap between one and the next.
    list_cmd_t cur_cmd;
    int        tx_gap  = 0;
    logic      tx_idle = 1'b1;
    logic      tx_free;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap   = 0;
        end else begin
            tx_free = !s_tvalid;
            if (s_tvalid && s_tready) begin
                apply_list_cmd(cur_cmd);
                cmds_accepted++;
                tx_free = 1'b1;
            end
            if (tx_free) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (cmd_q.size() > 0 &&
                             !(cmd_q[0].drain_first && expected_results.size() != 0)) begin
                    cur_cmd = cmd_q.pop_front();
                    s_tdata <= {3'b000, cur_cmd.value, cur_cmd.pos};
                    s_tuser <= cur_cmd.op;
                    s_tvalid <= 1'b1;
                    if ($urandom_range(0, 15) == 0)
                        tx_idle = !tx_idle;
                    tx_gap = tx_idle ? $urandom_range(0, 5) : 0;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result item against the oldest expectation and
    // stalls the receiver at random.
    list_result_t exp_r;
    list_result_t got_r;
    int           rx_stall = 0;
    logic         rx_idle  = 1'b1;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_stall = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                got_r.status     = m_tuser[1:0];
                got_r.elem_valid = m_tuser[2];
                got_r.element    = m_tdata[31:0];
                got_r.count      = m_tdata[36:32];
                got_r.last       = m_tlast;
                if (expected_results.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result item, actual %p", $time, got_r);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got_r !== exp_r) begin
                        error_count++;
                        $display("%0t: result mismatch, expected %p, actual %p",
                                 $time, exp_r, got_r);
                    end
                end
                if ($urandom_range(0, 15) == 0)
                    rx_idle = !rx_idle;
                rx_stall = rx_idle ? $urandom_range(0, 5) : 0;
            end
            if (rx_stall > 0) begin
                rx_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        repeat (TIMEOUT_CYCLES) @(posedge aclk);
        $display("%0t: timeout, %0d results still expected", $time,
                 expected_results.size());
        $display("[positional_insert_erase_list_unit] ERROR");
        $finish;
    end

    int n;
    int burst_left;
    int mode;
    int sel;
    int pos;
    logic [OP_W-1:0] op;

    initial begin
        // Directed part: empty-list cases, the unused code, edits at the front,
        // middle and end, and positions past the count.
        add_cmd(OP_DUMP,   0,  32'h0, 1'b0);
        add_cmd(OP_ERASE,  0,  32'h0, 1'b0);
        add_cmd(OP_INSERT, 1,  32'h5A5A_5A5A, 1'b0);
        add_cmd(OP_UNUSED, 31, 32'hFFFF_FFFF, 1'b0);
        add_cmd(OP_INSERT, 0,  32'h7FFF_FFFF, 1'b0);
        add_cmd(OP_INSERT, 1,  32'h8000_0000, 1'b0);
        add_cmd(OP_INSERT, 0,  32'h0000_0000, 1'b0);
        add_cmd(OP_INSERT, 2,  32'hFFFF_FFFF, 1'b0);
        add_cmd(OP_INSERT, 31, 32'h1234_5678, 1'b0);
        add_cmd(OP_DUMP,   0,  32'h0, 1'b0);
        add_cmd(OP_ERASE,  4,  32'h0, 1'b0);
        add_cmd(OP_ERASE,  31, 32'h0, 1'b0);
        add_cmd(OP_ERASE,  1,  32'h0, 1'b0);
        add_cmd(OP_ERASE,  2,  32'h0, 1'b0);
        add_cmd(OP_ERASE,  0,  32'h0, 1'b0);
        add_cmd(OP_UNUSED, 0,  32'h0, 1'b0);
        add_cmd(OP_DUMP,   0,  32'h0, 1'b0);
        add_cmd(OP_ERASE,  0,  32'h0, 1'b1);
        add_cmd(OP_DUMP,   0,  32'h0, 1'b0);

        // Random part in bursts: filling, draining or mixed. The first burst
        // is mostly inserts, aimed at filling the list so that full refusals occur.
        burst_left = 24;
        mode = 0;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(8, 30);
                mode = $urandom_range(0, 2);
            end
            burst_left--;
            sel = $urandom_range(0, 99);
            if (sel < 8)
                op = OP_DUMP;
            else if (sel < 11)
                op = OP_UNUSED;
            else if (mode == 0)
                op = (sel < 80) ? OP_INSERT : OP_ERASE;
            else if (mode == 1)
                op = (sel < 80) ? OP_ERASE : OP_INSERT;
            else
                op = (sel < 55) ? OP_INSERT : OP_ERASE;
            if ($urandom_range(0, 99) < 15)
                pos = $urandom_range(0, 31);
            else if (op == OP_INSERT)
                pos = $urandom_range(0, plan_len);
            else
                pos = (plan_len > 0) ? $urandom_range(0, plan_len - 1) : 0;
            add_cmd(op, pos, pick_value(), $urandom_range(0, 39) == 0);
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (cmd_q.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);

        $display("Ran %0d commands (%0d dumps) and checked %0d result items.",
                 cmds_accepted, dumps_done, results_seen);
        $display("List peaked at %0d entries; %0d full refusals, %0d bad positions.",
                 peak_len, full_refusals, bad_positions);
        if (error_count == 0) begin
            $display("[positional_insert_erase_list_unit] OK");
        end else begin
            $display("[positional_insert_erase_list_unit] ERROR");
        end
        $finish;
    end

endmodule
